// ===== rtl/tdpb_pkg.sv =====
// Shared types and constants for the tail-drop packet buffer timing block.
package tdpb_pkg;

    localparam int TIME_W = 32;
    localparam int PROC_W = 16;
    localparam int CAP_W  = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [PROC_W-1:0] proc_t;
    typedef logic [CAP_W-1:0]  cap_t;

    localparam time_t TIME_MAX = '1;

endpackage

// ===== rtl/tdpb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tdpb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tail_drop_packet_buffer_timing.sv =====
// Top level of the tail-drop packet buffer timing block.
//
// Input channel (in_valid/in_ready) takes one packet beat: arrival_tick and
// service_ticks. Output channel (out_valid/out_ready) returns one result beat
// per packet: dropped and begin_tick (zero when dropped). Configuration
// channel (cfg_valid/cfg_ready) writes buffer_capacity; it is always ready.
//
// Finish times of held packets sit in a ring RAM read at the head pointer.
// While a packet waits at the input, held entries whose finish time is at or
// before its arrival are retired one per cycle, with in_ready low. The packet
// is then accepted and its result appears in the output register on the
// next cycle. While entries are retired no new packet is accepted, and each
// packet pushes at most one entry; apart from output stalls, throughput is
// set by the one-entry-per-cycle retire loop through the RAM read port.
//
// Reset empties the ring (pointers and occupancy cleared), clears the last
// finish time and sets the capacity to 1024; no RAM clearing pass is needed.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken; retiring continues meanwhile.
module tail_drop_packet_buffer_timing #(
    parameter int DEPTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  tdpb_pkg::cap_t cfg_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  tdpb_pkg::time_t arrival_tick,
    input  tdpb_pkg::proc_t service_ticks,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           dropped,
    output tdpb_pkg::time_t begin_tick
);

    import tdpb_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    cap_t             cap_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    time_t            last_finish_reg, last_finish_next;
    logic             fwd_reg;
    time_t            fwd_data_reg;
    logic             out_valid_reg;
    logic             dropped_reg;
    time_t            start_reg;

    time_t            rd_data;
    time_t            head_finish;
    logic             retire;
    logic             slot_free;
    logic             accept;
    logic             full;
    logic [OCC_W-1:0] occ_after;
    logic [CMP_W-1:0] limit;
    time_t            start_val;
    logic [TIME_W:0]  sum;
    time_t            finish_val;
    logic             wr_en;

    assign head_finish = fwd_reg ? fwd_data_reg : rd_data;
    assign retire      = (occ_reg != '0) && (arrival_tick >= head_finish);
    assign slot_free   = !out_valid_reg || out_ready;
    assign in_ready    = slot_free && !retire;
    assign accept      = in_valid && in_ready;
    assign cfg_ready   = 1'b1;

    assign limit = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign full  = CMP_W'(occ_reg) >= limit;

    assign start_val  = (occ_reg == '0) ? arrival_tick : last_finish_reg;
    assign sum        = {1'b0, start_val} + (TIME_W + 1)'(service_ticks);
    assign finish_val = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    assign wr_en      = accept && !full;

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        occ_after        = occ_reg;
        occ_next         = occ_reg;
        last_finish_next = last_finish_reg;
        if (in_valid && retire)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
            occ_after = occ_reg - OCC_W'(1);
            occ_next  = occ_after;
        end
        if (wr_en)
        begin
            tail_next        = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
            occ_next         = occ_reg + OCC_W'(1);
            last_finish_next = finish_val;
        end
    end

    tdpb_ram #(
        .WIDTH (TIME_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (finish_val),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg         <= CAP_RESET;
            head_reg        <= '0;
            tail_reg        <= '0;
            occ_reg         <= '0;
            last_finish_reg <= '0;
            fwd_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            occ_reg         <= occ_next;
            last_finish_reg <= last_finish_next;
            // forward a write that lands on the entry being read
            fwd_reg         <= wr_en && (tail_reg == head_next);
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= finish_val;
        if (accept)
        begin
            dropped_reg <= full;
            start_reg   <= full ? '0 : start_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dropped    = dropped_reg;
    assign begin_tick = start_reg;

endmodule

// ===== rtl/tdpb_checker.sv =====
// Port-level checker for the tail-drop packet buffer timing block, with bind.
module tdpb_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input tdpb_pkg::time_t arrival_tick,
    input logic            out_valid,
    input logic            out_ready,
    input logic            dropped,
    input tdpb_pkg::time_t begin_tick
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dropped) && $stable(begin_tick))
        else $error("result beat changed while stalled");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> begin_tick == '0)
        else $error("dropped beat carries nonzero start time");

    a_one_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result beat one cycle after input beat");

    a_start_order: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> dropped || (begin_tick >= $past(arrival_tick)))
        else $error("start time before arrival time");

endmodule

bind tail_drop_packet_buffer_timing tdpb_checker u_tdpb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .arrival_tick (arrival_tick),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dropped      (dropped),
    .begin_tick   (begin_tick)
);
